// File: design/plb_pkg.sv
// Shared constants and types for the positional list buffer.
package plb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int OP_W      = 2;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 7;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_TAIL,
        ST_FINAL,
        ST_DONE
    } plb_state_t;

endpackage

// File: design/plb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/positional_list_buffer_top.sv
// Positional list buffer: ordered list with read, insert and remove at a position.
//
//   channel   ports                                     direction
//   s_        s_operation, s_position, s_value          in,  valid/ready
//   m_        m_ok, m_read_value, m_count               out, valid/ready
//
// A rejected beat goes straight to the result, a read waits for the registered RAM read,
// an insert at the end writes only the new value, and other inserts and removes first shift
// the later entries; the single write port of the entry RAM moves one entry per cycle.
// aresetn clears the count and control; entry storage is not cleared.
// A new beat is accepted only in idle, in the cycle after the result loads; a waiting
// result holds in the output register and stalls the list in its done state.
module positional_list_buffer_top
    import plb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic [POS_W-1:0]          s_position,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic signed [DATA_W-1:0]  m_read_value,
    output logic [COUNT_W-1:0]        m_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] DEPTH_EXT = CMPW'(DEPTH);

    plb_state_t          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       stop_reg, stop_next;
    logic [AW-1:0]       wr_addr_reg, wr_addr_next;
    logic                wr_pend_reg, wr_pend_next;
    logic                ins_reg, ins_next;
    logic                res_ok_reg, res_ok_next;
    logic [DATA_W-1:0]   res_rd_reg, res_rd_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_ok_reg, m_ok_next;
    logic [DATA_W-1:0]   m_rd_reg, m_rd_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic [CMPW-1:0]     pos_ext;
    logic [CMPW-1:0]     cnt_ext;
    logic                load_out;

    plb_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign pos_ext = CMPW'(s_position);
    assign cnt_ext = CMPW'(count_reg);

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_read_value = m_rd_reg;
    assign m_count      = m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        stop_reg    <= stop_next;
        wr_addr_reg <= wr_addr_next;
        ins_reg     <= ins_next;
        res_ok_reg  <= res_ok_next;
        res_rd_reg  <= res_rd_next;
        m_ok_reg    <= m_ok_next;
        m_rd_reg    <= m_rd_next;
        m_count_reg <= m_count_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        stop_next    = stop_reg;
        wr_addr_next = wr_addr_reg;
        wr_pend_next = wr_pend_reg;
        ins_next     = ins_reg;
        res_ok_next  = res_ok_reg;
        res_rd_next  = res_rd_reg;
        m_ok_next    = m_ok_reg;
        m_rd_next    = m_rd_reg;
        m_count_next = m_count_reg;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = pos_ext[AW-1:0];
                if (s_valid) begin
                    res_ok_next  = 1'b0;
                    res_rd_next  = '0;
                    wr_pend_next = 1'b0;
                    pos_next     = pos_ext[AW-1:0];
                    val_next     = s_value;
                    state_next   = ST_DONE;
                    case (s_operation)
                        OP_READ: begin
                            if (pos_ext < cnt_ext) begin
                                res_ok_next = 1'b1;
                                state_next  = ST_READ;
                            end
                        end
                        OP_INSERT: begin
                            if (pos_ext <= cnt_ext && cnt_ext < DEPTH_EXT) begin
                                res_ok_next = 1'b1;
                                count_next  = CW'(count_reg + 1'b1);
                                if (pos_ext == cnt_ext) begin
                                    state_next = ST_FINAL;
                                end else begin
                                    idx_next   = AW'(count_reg - 1'b1);
                                    stop_next  = pos_ext[AW-1:0];
                                    ins_next   = 1'b1;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_ext < cnt_ext) begin
                                res_ok_next = 1'b1;
                                count_next  = CW'(count_reg - 1'b1);
                                if (CMPW'(pos_ext + 1'b1) != cnt_ext) begin
                                    idx_next   = AW'(pos_ext + 1'b1);
                                    stop_next  = AW'(count_reg - 1'b1);
                                    ins_next   = 1'b0;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_rd_next = ram_rdata;
                state_next  = ST_DONE;
            end
            ST_SHIFT: begin
                ram_we       = wr_pend_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = ins_reg ? AW'(idx_reg + 1'b1) : AW'(idx_reg - 1'b1);
                idx_next     = ins_reg ? AW'(idx_reg - 1'b1) : AW'(idx_reg + 1'b1);
                if (idx_reg == stop_reg) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                ram_we       = 1'b1;
                wr_pend_next = 1'b0;
                state_next   = ins_reg ? ST_FINAL : ST_DONE;
            end
            ST_FINAL: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = val_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_rd_next    = res_rd_reg;
                    m_count_next = cnt_ext[COUNT_W-1:0];
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(count_reg) <= DEPTH_EXT)
        else $error("entry count exceeds depth");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_value == '0)
        else $error("rejected beat carries nonzero read value");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("RAM write while idle");

    a_count_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready) |=> $stable(count_reg))
        else $error("count changed without an accepted beat");

endmodule

// File: sim/tb_positional_list_buffer_top.sv
// Self-checking testbench for positional_list_buffer_top: directed, full-list and random beats.
module tb_positional_list_buffer_top
    import plb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = DEPTH + 8;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    logic                     aclk         = 1'b0;
    logic                     aresetn      = 1'b0;
    logic                     s_valid      = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation  = OP_READ;
    logic [POS_W-1:0]         s_position   = '0;
    logic signed [DATA_W-1:0] s_value      = '0;
    logic                     m_valid;
    logic                     m_ready      = 1'b0;
    logic                     m_ok;
    logic signed [DATA_W-1:0] m_read_value;
    logic [COUNT_W-1:0]       m_count;

    logic signed [DATA_W-1:0] list_model [DEPTH];
    int                       list_len     = 0;
    list_result_t             pending_results [$];
    int                       error_count  = 0;
    int                       cycle_count  = 0;
    int                       s_idle_pct   = 22;
    int                       m_idle_pct   = 83;

    positional_list_buffer_top #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_ok        (m_ok),
        .m_read_value(m_read_value),
        .m_count     (m_count)
    );

    always #2 aclk = ~aclk;

    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           p;
        r  = '0;
        p  = int'(pos);
        case (op)
            OP_READ: begin
                if (p < list_len) begin
                    r.ok         = 1'b1;
                    r.read_value = list_model[p];
                end
            end
            OP_INSERT: begin
                if (p <= list_len && list_len < DEPTH) begin
                    for (int i = list_len; i > p; i--) begin
                        list_model[i] = list_model[i-1];
                    end
                    list_model[p] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (p < list_len) begin
                    for (int i = p; i + 1 < list_len; i++) begin
                        list_model[i] = list_model[i+1];
                    end
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_beat(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
        if ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < s_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    task automatic test_directed();
        send_beat(OP_READ,   7'd0,   32'sd0);
        send_beat(OP_REMOVE, 7'd0,   32'sd0);
        send_beat(OP_INSERT, 7'd1,   32'sd5);
        send_beat(OP_INSERT, 7'd0,   32'sh8000_0000);
        send_beat(OP_INSERT, 7'd1,   32'sh7fff_ffff);
        send_beat(OP_INSERT, 7'd1,   32'sd0);
        send_beat(OP_INSERT, 7'd0,   -32'sd1);
        send_beat(OP_READ,   7'd0,   32'sd0);
        send_beat(OP_READ,   7'd1,   32'sd0);
        send_beat(OP_READ,   7'd2,   32'sd0);
        send_beat(OP_READ,   7'd3,   32'sd0);
        send_beat(OP_READ,   7'd4,   32'sd0);
        send_beat(OP_READ,   7'd127, 32'sd0);
        send_beat(OP_UNUSED, 7'd0,   -32'sd1);
        send_beat(OP_INSERT, 7'd127, -32'sd1);
        send_beat(OP_REMOVE, 7'd1,   32'sd0);
        send_beat(OP_REMOVE, 7'd2,   32'sd0);
        send_beat(OP_READ,   7'd2,   32'sd0);
        send_beat(OP_INSERT, 7'd2,   32'sh5555_5555);
        send_beat(OP_READ,   7'd2,   32'sd0);
        send_beat(OP_REMOVE, 7'd127, 32'sd0);
        send_beat(OP_REMOVE, 7'd0,   32'sd0);
        send_beat(OP_READ,   7'd0,   -32'sd1);
        send_beat(OP_UNUSED, 7'd127, 32'sh2aaa_aaaa);
    endtask

    task automatic test_full_list();
        while (list_len < DEPTH) begin
            send_beat(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
        end
        send_beat(OP_INSERT, 7'd0, $urandom);
        send_beat(OP_INSERT, POS_W'(DEPTH), $urandom);
        send_beat(OP_READ, POS_W'(DEPTH - 1), 32'sd0);
        send_beat(OP_READ, POS_W'(DEPTH), 32'sd0);
        send_beat(OP_READ, 7'd0, 32'sd0);
        send_beat(OP_REMOVE, POS_W'(DEPTH - 1), 32'sd0);
        send_beat(OP_INSERT, POS_W'(DEPTH - 1), $urandom);
        send_beat(OP_REMOVE, 7'd0, 32'sd0);
        send_beat(OP_READ, POS_W'(DEPTH - 2), 32'sd0);
    endtask

    task automatic test_random_phase(int beats, int sender_pct, int receiver_pct);
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               roll;
        s_idle_pct = sender_pct;
        m_idle_pct = receiver_pct;
        repeat (beats) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                op  = OP_W'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 127));
            end else begin
                if (roll < 40) begin
                    op = OP_READ;
                end else if (int'($urandom_range(0, DEPTH - 1)) >= list_len) begin
                    op = OP_INSERT;
                end else begin
                    op = OP_REMOVE;
                end
                if (op == OP_INSERT) begin
                    pos = POS_W'($urandom_range(0, list_len));
                end else if (list_len == 0) begin
                    pos = '0;
                end else if ($urandom_range(0, 9) < 2) begin
                    pos = $urandom_range(0, 1) ? POS_W'(list_len - 1) : '0;
                end else begin
                    pos = POS_W'($urandom_range(0, list_len - 1));
                end
            end
            send_beat(op, pos, $urandom);
        end
    endtask

    always @(posedge aclk) begin : result_check
        list_result_t want;
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report($sformatf("result beat with nothing pending (ok %0b count %0d)",
                                 m_ok, m_count));
            end else begin
                want = pending_results.pop_front();
                if (m_ok !== want.ok) begin
                    report($sformatf("ok expected %0b got %0b", want.ok, m_ok));
                end
                if (m_read_value !== want.read_value) begin
                    report($sformatf("read_value expected %0d got %0d",
                                     want.read_value, m_read_value));
                end
                if (m_count !== want.count) begin
                    report($sformatf("count expected %0d got %0d", want.count, m_count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_list();
        test_random_phase(420, 22, 83);
        test_random_phase(420, 83, 22);
        test_random_phase(420, 0, 0);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
